/* rtl/hbc_pkg.sv */
// Shared types, constants and codes for the hashed block cache.
`timescale 1ns / 1ps
`default_nettype none
package hbc_pkg;

  localparam int SET_COUNT_DEF = 1024;
  localparam int WAY_COUNT_DEF = 8;

  localparam int HASH_W = 64;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 13;
  localparam int LIFE_W = 16;
  localparam int OUT_W  = 2;
  localparam int WAYO_W = 3;

  localparam logic [LIFE_W-1:0] LIFE_FULL = {LIFE_W{1'b1}};

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [OUT_W-1:0] OC_READ_HIT   = 2'd0;
  localparam logic [OUT_W-1:0] OC_READ_MISS  = 2'd1;
  localparam logic [OUT_W-1:0] OC_WR_REFRESH = 2'd2;
  localparam logic [OUT_W-1:0] OC_WR_NEW     = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [HASH_W-1:0] hash_high;
    logic [HASH_W-1:0] hash_low;
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0]  outcome;
    logic [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]  copied_length;
    logic [WAYO_W-1:0] way_used;
  } rsp_t;

  // one way of a set row
  typedef struct packed {
    logic [HASH_W-1:0] tag_upper;
    logic [HASH_W-1:0] tag_lower;
    logic [DATA_W-1:0] data;
    logic [LIFE_W-1:0] life;
  } way_t;

  // verdict of the shared way compare unit
  typedef struct packed {
    logic              match;
    logic              live;
    logic              younger;
    logic [LIFE_W-1:0] life_dec;
  } way_chk_t;

endpackage
`default_nettype wire

/* rtl/hashed_block_cache_with_aging_top.sv */
// Top level of the hashed block cache with life-based aging.
`timescale 1ns / 1ps
`default_nettype none
// Set-associative cache of SET_COUNT sets by WAY_COUNT ways keyed by a 128-bit
// hash; each word in gives exactly one word out. One word at a time is worked:
// the set index is formed (directly when SET_COUNT is a power of two, by a
// chunked modulo otherwise), the set row is read, then a single compare unit
// walks the ways one per cycle, and the updated row is written back as the
// result is loaded. The result register lets the next word be accepted while
// a result waits. After reset a clearing pass zeroes every set of the memory;
// req_ready stays low then.
module hashed_block_cache_with_aging_top #(
  parameter int SET_COUNT = hbc_pkg::SET_COUNT_DEF,
  parameter int WAY_COUNT = hbc_pkg::WAY_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  hbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output hbc_pkg::rsp_t rsp
);

  localparam int SET_W = $clog2(SET_COUNT);
  localparam int WAY_W = $clog2(WAY_COUNT);
  localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(WAY_COUNT - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                    state;
  hbc_pkg::req_t                 req_q;
  logic [SET_W-1:0]              set_q;
  hbc_pkg::way_t [WAY_COUNT-1:0] row;
  hbc_pkg::way_t [WAY_COUNT-1:0] wb_row;
  hbc_pkg::way_t [WAY_COUNT-1:0] rd_row;
  hbc_pkg::way_t                 ent;
  hbc_pkg::way_chk_t             chk;
  logic [WAY_W-1:0]              way_idx;
  logic                          hit_found;
  logic [WAY_W-1:0]              hit_way;
  logic [hbc_pkg::DATA_W-1:0]    hit_data;
  logic [WAY_W-1:0]              victim;
  logic [hbc_pkg::LIFE_W-1:0]    victim_life;
  logic                          clearing;
  logic                          mod_start;
  logic                          mod_done;
  logic [SET_W-1:0]              mod_idx;
  logic                          fin_go;
  logic [WAY_W+2:0]              hit_ext;
  logic [WAY_W+2:0]              vic_ext;
  hbc_pkg::rsp_t                 rsp_next;

  assign req_ready = (state == S_IDLE) && !clearing;
  assign mod_start = req_valid && req_ready;
  assign fin_go    = (state == S_FIN) && (!rsp_valid || rsp_ready);
  assign ent       = row[way_idx];
  assign hit_ext   = {3'b000, hit_way};
  assign vic_ext   = {3'b000, victim};

  hbc_set_idx #(
    .SET_COUNT(SET_COUNT)
  ) u_set_idx (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (req.hash_low),
    .done   (mod_done),
    .set_idx(mod_idx)
  );

  hbc_set_mem #(
    .SET_COUNT(SET_COUNT),
    .WAY_COUNT(WAY_COUNT)
  ) u_set_mem (
    .clk     (clk),
    .rst     (rst),
    .clearing(clearing),
    .rd_en   (mod_done),
    .rd_addr (mod_idx),
    .rd_row  (rd_row),
    .wr_en   (fin_go),
    .wr_addr (set_q),
    .wr_row  (wb_row)
  );

  hbc_way_cmp u_way_cmp (
    .ent        (ent),
    .hash_high  (req_q.hash_high),
    .hash_low   (req_q.hash_low),
    .victim_life(victim_life),
    .chk        (chk)
  );

  // final row update and result word
  always_comb begin
    wb_row   = row;
    rsp_next = '0;
    if (req_q.req_type == hbc_pkg::REQ_WRITE) begin
      if (hit_found) begin
        wb_row[hit_way].life = hbc_pkg::LIFE_FULL;
        rsp_next.outcome     = hbc_pkg::OC_WR_REFRESH;
        rsp_next.way_used    = hit_ext[2:0];
      end else begin
        wb_row[victim].tag_upper = req_q.hash_high;
        wb_row[victim].tag_lower = req_q.hash_low;
        wb_row[victim].data      = req_q.payload;
        wb_row[victim].life      = hbc_pkg::LIFE_FULL;
        rsp_next.outcome         = hbc_pkg::OC_WR_NEW;
        rsp_next.way_used        = vic_ext[2:0];
      end
    end else if (hit_found) begin
      rsp_next.outcome       = hbc_pkg::OC_READ_HIT;
      rsp_next.data_out      = hit_data;
      rsp_next.copied_length = req_q.length;
      rsp_next.way_used      = hit_ext[2:0];
    end else begin
      rsp_next.outcome = hbc_pkg::OC_READ_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (mod_start) begin
            req_q <= req;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            set_q <= mod_idx;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          row         <= rd_row;
          way_idx     <= '0;
          hit_found   <= 1'b0;
          victim      <= '0;
          victim_life <= hbc_pkg::LIFE_FULL;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (req_q.req_type == hbc_pkg::REQ_READ) begin
            if (chk.live) begin
              if (chk.match) begin
                // later equal tags keep their life
                if (!hit_found) begin
                  hit_found <= 1'b1;
                  hit_way   <= way_idx;
                  hit_data  <= ent.data;
                end
              end else begin
                row[way_idx].life <= chk.life_dec;
              end
            end
          end else if (!hit_found) begin
            // writes match dead ways too
            if (chk.match) begin
              hit_found <= 1'b1;
              hit_way   <= way_idx;
            end else if (chk.younger) begin
              victim      <= way_idx;
              victim_life <= ent.life;
            end
          end
          if (way_idx == WAY_LAST) begin
            state <= S_FIN;
          end else begin
            way_idx <= way_idx + WAY_W'(1);
          end
        end
        S_FIN: begin
          if (fin_go) begin
            rsp   <= rsp_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FIN))
    else $error("result word loaded outside the finish step");

  a_mod_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("set index finished while not waiting for it");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.outcome != hbc_pkg::OC_READ_HIT)) |->
      (rsp.data_out == '0) && (rsp.copied_length == '0))
    else $error("data or length on a result that is not a read hit");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (state == S_IDLE) && !rsp_valid)
    else $error("work in progress during the clearing pass");

endmodule
`default_nettype wire

/* rtl/hbc_way_cmp.sv */
// Shared way compare unit: tag match, liveness, aging and victim compare.
`timescale 1ns / 1ps
`default_nettype none
module hbc_way_cmp (
  input  hbc_pkg::way_t                   ent,
  input  logic [hbc_pkg::HASH_W-1:0]      hash_high,
  input  logic [hbc_pkg::HASH_W-1:0]      hash_low,
  input  logic [hbc_pkg::LIFE_W-1:0]      victim_life,
  output hbc_pkg::way_chk_t               chk
);

  always_comb begin
    chk.match    = (ent.tag_upper == hash_high) && (ent.tag_lower == hash_low);
    chk.live     = (ent.life != '0);
    chk.younger  = (ent.life < victim_life);
    chk.life_dec = ent.life - hbc_pkg::LIFE_W'(1);
  end

endmodule
`default_nettype wire

/* rtl/hbc_set_idx.sv */
// Set index unit: hash_low modulo SET_COUNT, folded 16 bits per step unless a power of two.
`timescale 1ns / 1ps
`default_nettype none
module hbc_set_idx #(
  parameter int SET_COUNT = hbc_pkg::SET_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hbc_pkg::HASH_W-1:0]   value,
  output logic                         done,
  output logic [$clog2(SET_COUNT)-1:0] set_idx
);

  localparam int  SET_W   = $clog2(SET_COUNT);
  localparam int  CHUNK_W = 16;
  localparam int  T_W     = 2 * CHUNK_W;
  localparam int  R_W     = CHUNK_W + 1;
  localparam int  CHUNKS  = hbc_pkg::HASH_W / CHUNK_W;
  localparam int  CNT_W   = $clog2(CHUNKS);
  localparam bit  POW2    = ((SET_COUNT & (SET_COUNT - 1)) == 0);
  localparam logic [T_W-1:0]   MODV     = T_W'(SET_COUNT);
  localparam logic [T_W-1:0]   RECIP    = T_W'((64'd1 << T_W) / 64'(SET_COUNT));
  localparam logic [R_W-1:0]   MODV_R   = R_W'(SET_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNKS - 1);

  localparam logic [1:0] P_MUL = 2'd0;
  localparam logic [1:0] P_SUB = 2'd1;
  localparam logic [1:0] P_FIX = 2'd2;

  logic                       busy;
  logic [1:0]                 phase;
  logic [CNT_W-1:0]           cnt;
  logic [hbc_pkg::HASH_W-1:0] val;
  logic [CHUNK_W-1:0]         rem;
  logic [CHUNK_W-1:0]         quo;
  logic [R_W-1:0]             part;
  logic [T_W-1:0]             t;
  logic [2*T_W-1:0]           prod;
  logic [T_W-1:0]             qm;

  // one Horner step per chunk: rem = (rem * 2^16 + chunk) mod SET_COUNT
  assign t       = {rem, val[hbc_pkg::HASH_W-1 -: CHUNK_W]};
  assign prod    = {{T_W{1'b0}}, t} * {{T_W{1'b0}}, RECIP};
  assign qm      = {{CHUNK_W{1'b0}}, quo} * MODV;
  assign set_idx = rem[SET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      phase <= P_MUL;
    end else begin
      done <= start ? POW2 : (busy && (phase == P_FIX) && (cnt == CNT_LAST));
      if (start) begin
        if (POW2) begin
          rem <= CHUNK_W'(value[SET_W-1:0]);
        end else begin
          rem   <= '0;
          val   <= value;
          cnt   <= '0;
          phase <= P_MUL;
          busy  <= 1'b1;
        end
      end else if (busy) begin
        case (phase)
          P_MUL: begin
            // reciprocal estimate, at most one below the true quotient
            quo   <= prod[T_W +: CHUNK_W];
            phase <= P_SUB;
          end
          P_SUB: begin
            part  <= R_W'(t - qm);
            phase <= P_FIX;
          end
          P_FIX: begin
            rem   <= (part >= MODV_R) ? CHUNK_W'(part - MODV_R) : part[CHUNK_W-1:0];
            val   <= {val[hbc_pkg::HASH_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            cnt   <= cnt + CNT_W'(1);
            phase <= P_MUL;
            if (cnt == CNT_LAST) begin
              busy <= 1'b0;
            end
          end
          default: begin
            phase <= P_MUL;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hbc_set_mem.sv */
// Set row memory: one row of all ways per set, with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module hbc_set_mem #(
  parameter int SET_COUNT = hbc_pkg::SET_COUNT_DEF,
  parameter int WAY_COUNT = hbc_pkg::WAY_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  output logic                                 clearing,
  input  logic                                 rd_en,
  input  logic [$clog2(SET_COUNT)-1:0]         rd_addr,
  output hbc_pkg::way_t [WAY_COUNT-1:0]        rd_row,
  input  logic                                 wr_en,
  input  logic [$clog2(SET_COUNT)-1:0]         wr_addr,
  input  hbc_pkg::way_t [WAY_COUNT-1:0]        wr_row
);

  localparam int SET_W = $clog2(SET_COUNT);
  localparam logic [SET_W-1:0] ADDR_LAST = SET_W'(SET_COUNT - 1);

  hbc_pkg::way_t [WAY_COUNT-1:0] mem [SET_COUNT];
  logic [SET_W-1:0]              clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SET_W'(1);
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
